/* rtl/itoa_pkg.sv */
// Shared types and codes of the integer to ASCII formatter.
package itoa_pkg;

  localparam logic [2:0] KIND_SDEC   = 3'd0;
  localparam logic [2:0] KIND_UDEC   = 3'd1;
  localparam logic [2:0] KIND_HEX_LO = 3'd2;
  localparam logic [2:0] KIND_HEX_UP = 3'd3;
  localparam logic [2:0] KIND_PTR    = 3'd4;

  localparam logic [1:0] PRE_NONE  = 2'd0;
  localparam logic [1:0] PRE_MINUS = 2'd1;
  localparam logic [1:0] PRE_HEX   = 2'd2;
  localparam logic [1:0] PRE_NIL   = 2'd3;

  localparam int TEXT_MAX = 20;
  localparam int DIGITS   = 20;

  typedef struct packed {
    logic        dec;
    logic        upper;
    logic [1:0]  prefix;
    logic [63:0] mag;
  } job_t;

endpackage

/* rtl/itoa_front.sv */
// Front end: accepts requests, classifies them and queues conversion jobs.
module itoa_front #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         req_type,
  input  logic [63:0]        value,
  output logic               q_valid,
  output itoa_pkg::job_t     q_job,
  input  logic               q_pop
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  itoa_pkg::job_t mem [DEPTH];
  logic [PW-1:0]  wptr;
  logic [PW-1:0]  rptr;
  logic [CW-1:0]  count;
  itoa_pkg::job_t job;
  logic           known;
  logic           wr;
  logic           rd;

  always_comb begin
    job.dec    = 1'b0;
    job.upper  = 1'b0;
    job.prefix = itoa_pkg::PRE_NONE;
    job.mag    = value;
    known      = 1'b1;
    case (req_type)
      itoa_pkg::KIND_SDEC: begin
        job.dec = 1'b1;
        if (value[63]) begin
          job.prefix = itoa_pkg::PRE_MINUS;
          job.mag    = ~value + 64'd1;
        end
      end
      itoa_pkg::KIND_UDEC: begin
        job.dec = 1'b1;
        job.mag = {32'd0, value[31:0]};
      end
      itoa_pkg::KIND_HEX_LO: begin
      end
      itoa_pkg::KIND_HEX_UP: begin
        job.upper = 1'b1;
      end
      itoa_pkg::KIND_PTR: begin
        job.prefix = (value == 64'd0) ? itoa_pkg::PRE_NIL : itoa_pkg::PRE_HEX;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  assign full    = (count == CW'(DEPTH));
  assign wr      = push && !full && known;
  assign q_valid = (count != '0);
  assign rd      = q_pop && q_valid;
  assign q_job   = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      end
      if (rd) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      end
      if (wr && !rd) begin
        count <= count + CW'(1);
      end else if (rd && !wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

/* rtl/itoa_back.sv */
// Back end: binary to BCD conversion of decimal jobs, digit counting and character output.
module itoa_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  itoa_pkg::job_t q_job,
  output logic           q_pop,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     out_char,
  output logic           last,
  output logic [4:0]     text_length
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_SIZE = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]                          state;
  itoa_pkg::job_t                      job;
  logic [63:0]                         bin;
  logic [itoa_pkg::DIGITS-1:0][3:0]    digits;
  logic [itoa_pkg::DIGITS-1:0][3:0]    adj;
  logic [5:0]                          cnt;
  logic [4:0]                          tlen;
  logic [4:0]                          pos;
  logic [4:0]                          ndig;
  logic [2:0]                          npre;
  logic [4:0]                          didx;
  logic [3:0]                          nib;
  logic [7:0]                          ch;
  logic                                ov;
  logic                                fin;
  logic                                emit;

  function automatic logic [7:0] prefix_char(input logic [1:0] pre, input logic [2:0] p);
    logic [7:0] c;
    c = "-";
    case (pre)
      itoa_pkg::PRE_HEX: begin
        c = (p == 3'd0) ? "0" : "x";
      end
      itoa_pkg::PRE_NIL: begin
        case (p)
          3'd0:    c = "(";
          3'd1:    c = "n";
          3'd2:    c = "i";
          3'd3:    c = "l";
          default: c = ")";
        endcase
      end
      default: begin
        c = "-";
      end
    endcase
    return c;
  endfunction

  always_comb begin
    for (int i = 0; i < itoa_pkg::DIGITS; i++) begin
      adj[i] = (digits[i] >= 4'd5) ? digits[i] + 4'd3 : digits[i];
    end
  end

  always_comb begin
    ndig = 5'd1;
    for (int i = 1; i < itoa_pkg::DIGITS; i++) begin
      if (digits[i] != 4'd0) begin
        ndig = 5'(i + 1);
      end
    end
    if (job.prefix == itoa_pkg::PRE_NIL) begin
      ndig = 5'd0;
    end
    case (job.prefix)
      itoa_pkg::PRE_MINUS: npre = 3'd1;
      itoa_pkg::PRE_HEX:   npre = 3'd2;
      itoa_pkg::PRE_NIL:   npre = 3'd5;
      default:             npre = 3'd0;
    endcase
  end

  always_comb begin
    didx = tlen - 5'd1 - pos;
    nib  = digits[didx];
    if (pos < {2'b00, npre}) begin
      ch = prefix_char(job.prefix, pos[2:0]);
    end else if (nib < 4'd10) begin
      ch = 8'h30 + {4'd0, nib};
    end else begin
      ch = (job.upper ? 8'h41 : 8'h61) + {4'd0, nib} - 8'd10;
    end
  end

  assign fin   = (pos == tlen - 5'd1);
  assign emit  = (state == S_EMIT) && (!ov || pop);
  assign q_pop = (state == S_IDLE) && q_valid;
  assign empty = !ov;

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          job <= q_job;
          bin <= q_job.mag;
          cnt <= '0;
          if (q_job.dec) begin
            digits <= '0;
          end else begin
            digits <= {16'd0, q_job.mag};
          end
        end
      end
      S_CONV: begin
        {digits, bin} <= {adj, bin} << 1;
        cnt           <= cnt + 6'd1;
      end
      S_SIZE: begin
        tlen <= {2'b00, npre} + ndig;
        pos  <= '0;
      end
      default: begin
        if (emit) begin
          pos <= pos + 5'd1;
        end
      end
    endcase
    if (emit) begin
      out_char    <= ch;
      last        <= fin;
      text_length <= fin ? tlen : 5'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ov    <= 1'b0;
    end else begin
      if (emit) begin
        ov <= 1'b1;
      end else if (pop) begin
        ov <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            state <= q_job.dec ? S_CONV : S_SIZE;
          end
        end
        S_CONV: begin
          if (cnt == 6'd63) begin
            state <= S_SIZE;
          end
        end
        S_SIZE: begin
          state <= S_EMIT;
        end
        default: begin
          if (emit && fin) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

/* rtl/integer_to_ascii_formatter_unit.sv */
// Top level of the integer to ASCII formatter.
// Requests enter through push and full: a request carries req_type and value
// and is taken at a clock edge where push is high and full is low. Kinds five
// to seven are taken and dropped without any output.
// Characters leave through empty and pop, most significant digit first; the
// character on out_char is taken at an edge where pop is high and empty is low.
// The final character of a text carries last and the text length.
// Decimal kinds pass through the shift and add-3 BCD converter, one bit per
// cycle, before the text is sized and emitted; hex and pointer kinds skip it
// and go straight from the queue to sizing. Characters then follow one per
// cycle while pop stays high. The converter takes the next job from the queue
// only after the final character of the current text has been emitted.
// A small request queue lets new requests in while a conversion runs.
// If the receiver stops popping, the character register holds and the
// converter waits; once the queue fills, full rises.
// Reset empties the queue and the output and returns the converter to idle.
module integer_to_ascii_formatter_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  req_type,
  input  logic [63:0] value,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_char,
  output logic        last,
  output logic [4:0]  text_length
);

  logic           q_valid;
  logic           q_pop;
  itoa_pkg::job_t q_job;

  itoa_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .req_type (req_type),
    .value    (value),
    .q_valid  (q_valid),
    .q_job    (q_job),
    .q_pop    (q_pop)
  );

  itoa_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_job       (q_job),
    .q_pop       (q_pop),
    .empty       (empty),
    .pop         (pop),
    .out_char    (out_char),
    .last        (last),
    .text_length (text_length)
  );

`ifndef NO_ASSERTIONS
  a_last_len: assert property (@(posedge clk) disable iff (rst)
    (!empty && last) |->
      (text_length != 5'd0 && text_length <= 5'(itoa_pkg::TEXT_MAX)))
    else $error("final character without a valid length");
  a_mid_len: assert property (@(posedge clk) disable iff (rst)
    (!empty && !last) |-> (text_length == 5'd0))
    else $error("length shown before the final character");
  a_qpop: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("job taken from an empty queue");
  a_reset: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("reset did not clear the queues");
`endif

endmodule
